// ----- rtl/ajp_pkg.sv -----
// Shared types and constants of the auto joypad poll sequencer.
package ajp_pkg;

    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_ENABLE = 2'd1;
    localparam logic [1:0] KIND_FRAME  = 2'd2;

    localparam logic [5:0]  IDLE_STEP           = 6'd33;
    localparam logic [10:0] H_START_LOW         = 11'd130;
    localparam logic [10:0] H_START_HIGH        = 11'd384;
    localparam logic [8:0]  DISPLAY_LINES_RESET = 9'd225;
    localparam logic [4:0]  BIT_COUNT           = 5'd16;

    typedef struct packed {
        logic [1:0]  kind;
        logic [10:0] h_position;
        logic [8:0]  v_position;
        logic        enable_value;
        logic [11:0] pad1_buttons;
        logic [11:0] pad2_buttons;
    } t_item;

    typedef struct packed {
        logic [15:0] joy1_value;
        logic [15:0] joy2_value;
        logic [5:0]  step_value;
    } t_result;

endpackage

// ----- rtl/ajp_in_stage.sv -----
// Input register stage that holds one accepted request until the core takes it.
module ajp_in_stage
    import ajp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_item i_item,
    input  logic  i_advance,
    output logic  o_stall,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  accept;

    assign o_stall = r_valid && !i_advance;
    assign accept  = i_in_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- rtl/ajp_seq_core.sv -----
// Poll sequencer state, its next-state logic and the result register.
module ajp_seq_core
    import ajp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  logic [8:0] i_cfg_data,
    input  logic    i_advance,
    input  t_item   i_item,
    output t_result o_result
);

    function automatic logic [15:0] pad_format(input logic [11:0] p);
        logic [15:0] v;
        v        = 16'd0;
        v[15:12] = p[11:8];
        v[11]    = p[7] & ~p[6];
        v[10]    = p[6] & ~p[7];
        v[9]     = p[5] & ~p[4];
        v[8]     = p[4] & ~p[5];
        v[7:4]   = p[3:0];
        return v;
    endfunction

    logic [8:0]  r_display_lines;
    logic        r_en,  n_en;
    logic [5:0]  r_step, n_step;
    logic        r_hp,  n_hp;
    logic [15:0] r_l1, n_l1, r_l2, n_l2;
    logic        r_b1, n_b1, r_b2, n_b2;
    logic [4:0]  r_bi, n_bi;
    logic [15:0] r_j1, n_j1, r_j2, n_j2;
    t_result     r_result;

    always_comb begin
        logic [5:0] s;
        logic       start;
        logic       go;
        n_en   = r_en;
        n_step = r_step;
        n_hp   = r_hp;
        n_l1   = r_l1;
        n_l2   = r_l2;
        n_b1   = r_b1;
        n_b2   = r_b2;
        n_bi   = r_bi;
        n_j1   = r_j1;
        n_j2   = r_j2;
        s      = r_step;
        start  = 1'b0;
        go     = 1'b0;
        if (i_advance) begin
            unique case (i_item.kind)
                KIND_TICK: begin
                    n_hp  = ~r_hp;
                    start = (i_item.v_position == r_display_lines) && n_hp &&
                            (i_item.h_position >= H_START_LOW) &&
                            (i_item.h_position <= H_START_HIGH);
                    go = 1'b1;
                    if (start) begin
                        s = 6'd0;
                    end else if (r_step >= IDLE_STEP) begin
                        go = 1'b0;
                    end else begin
                        s = r_step + 6'd1;
                    end
                    n_step = s;
                    if (go) begin
                        if (s == 6'd0 && r_en) begin
                            n_l1 = pad_format(i_item.pad1_buttons);
                            n_l2 = pad_format(i_item.pad2_buttons);
                            n_j1 = 16'd0;
                            n_j2 = 16'd0;
                            n_bi = 5'd0;
                        end
                        if (s != 6'd1 && !r_en) begin
                            // Polling is off: the run ends here.
                            n_step = IDLE_STEP;
                        end else if (s >= 6'd2) begin
                            if (!s[0]) begin
                                // Even step: fetch the next bit, MSB first.
                                if (r_bi < BIT_COUNT) begin
                                    n_b1 = r_l1[~r_bi[3:0]];
                                    n_b2 = r_l2[~r_bi[3:0]];
                                end else begin
                                    n_b1 = 1'b1;
                                    n_b2 = 1'b1;
                                end
                            end else begin
                                n_j1 = {r_j1[14:0], r_b1};
                                n_j2 = {r_j2[14:0], r_b2};
                                if (r_bi < BIT_COUNT) begin
                                    n_bi = r_bi + 5'd1;
                                end
                            end
                        end
                    end
                end
                KIND_ENABLE: begin
                    n_en = i_item.enable_value;
                    if (!i_item.enable_value && r_step >= 6'd2 && r_step < IDLE_STEP) begin
                        n_step = IDLE_STEP;
                    end
                end
                KIND_FRAME: begin
                    n_step = IDLE_STEP;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_lines <= DISPLAY_LINES_RESET;
            r_en   <= 1'b0;
            r_step <= IDLE_STEP;
            r_hp   <= 1'b0;
            r_l1   <= 16'd0;
            r_l2   <= 16'd0;
            r_b1   <= 1'b0;
            r_b2   <= 1'b0;
            r_bi   <= 5'd0;
            r_j1   <= 16'd0;
            r_j2   <= 16'd0;
        end else begin
            if (i_cfg_we) begin
                r_display_lines <= i_cfg_data;
            end
            r_en   <= n_en;
            r_step <= n_step;
            r_hp   <= n_hp;
            r_l1   <= n_l1;
            r_l2   <= n_l2;
            r_b1   <= n_b1;
            r_b2   <= n_b2;
            r_bi   <= n_bi;
            r_j1   <= n_j1;
            r_j2   <= n_j2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_result.joy1_value <= n_j1;
            r_result.joy2_value <= n_j2;
            r_result.step_value <= n_step;
        end
    end

    assign o_result = r_result;

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= IDLE_STEP)
        else $error("poll step beyond idle");

    a_bit_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bi <= BIT_COUNT)
        else $error("bit index beyond sixteen");

    a_frame_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_item.kind == KIND_FRAME |=> r_step == IDLE_STEP)
        else $error("frame begin did not park the sequencer");

    a_disable_aborts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_item.kind == KIND_ENABLE && !i_item.enable_value
        |=> r_step <= 6'd1 || r_step == IDLE_STEP)
        else $error("clearing the enable did not end the run");

    a_result_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance |=> o_result.step_value == r_step && o_result.joy1_value == r_j1)
        else $error("result register out of step with state");
`endif

endmodule

// ----- rtl/auto_joypad_poll_sequencer.sv -----
// Top level of the auto joypad poll sequencer.
// This block runs the automatic joypad read sequence: each request is a tick, a write of
// the poll enable bit or a frame begin, and each request yields exactly one result holding
// both assembled joypad registers and the current poll step (33 means idle). It takes one
// request every clock cycle while o_in_stall is low. An accepted request is held in the
// input register and is written into the result register when it advances, which waits
// while an unread result is held by i_out_stall. Every request passes once through the
// input register in front of the state update in the sequencer core. The user must write
// the display line register through i_cfg_we and i_cfg_data only while no request is in
// flight; the block itself does not enforce this.
module auto_joypad_poll_sequencer
    import ajp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [10:0] i_h_position,
    input  logic [8:0]  i_v_position,
    input  logic        i_enable_value,
    input  logic [11:0] i_pad1_buttons,
    input  logic [11:0] i_pad2_buttons,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_joy1_value,
    output logic [15:0] o_joy2_value,
    output logic [5:0]  o_step_value
);

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    advance;
    t_result result;
    logic    r_out_valid;
    logic    n_out_valid;

    assign in_item.kind         = i_kind;
    assign in_item.h_position   = i_h_position;
    assign in_item.v_position   = i_v_position;
    assign in_item.enable_value = i_enable_value;
    assign in_item.pad1_buttons = i_pad1_buttons;
    assign in_item.pad2_buttons = i_pad2_buttons;

    // The held request moves into the core whenever the result register is empty or its
    // current result is being taken in this cycle.
    assign advance = held_valid && (!r_out_valid || !i_out_stall);

    ajp_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_item     (in_item),
        .i_advance  (advance),
        .o_stall    (o_in_stall),
        .o_valid    (held_valid),
        .o_item     (held_item)
    );

    ajp_seq_core u_seq_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_advance  (advance),
        .i_item     (held_item),
        .o_result   (result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_joy1_value = result.joy1_value;
    assign o_joy2_value = result.joy2_value;
    assign o_step_value = result.step_value;

endmodule
